// File: sv/rta_pkg.sv
package rta_pkg;

  localparam int ADDR_BITS   = 48;
  localparam int PAGE_BITS   = 12;
  localparam int PG_W        = ADDR_BITS - PAGE_BITS;
  localparam int MAX_REGIONS = 64;
  localparam int IDX_W       = $clog2(MAX_REGIONS);
  localparam int CNT_W       = $clog2(MAX_REGIONS + 1);
  localparam int ATTR_W      = 24;
  localparam int GUARD_W     = 16;
  localparam int CODE_W      = 8;
  localparam int CFG_IDX_W   = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BREAK = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MMAP_TOP   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GUARD      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HEAP_KIND  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_STACK_KIND = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_NO_MERGE   = 3'd5;

  localparam logic [GUARD_W-1:0] GUARD_RST      = 16'd16;
  localparam logic [CODE_W-1:0]  HEAP_KIND_RST  = 8'd1;
  localparam logic [CODE_W-1:0]  STACK_KIND_RST = 8'd2;
  localparam logic [CODE_W-1:0]  NO_MERGE_RST   = 8'd1;

  typedef struct packed {
    logic [PG_W-1:0]   pg_start;
    logic [PG_W-1:0]   pg_end;
    logic [ATTR_W-1:0] attr;
  } region_t;

  typedef struct packed {
    logic [PG_W-1:0] pg_start;
    logic [PG_W-1:0] pg_end;
  } free_t;

  typedef enum logic [1:0] {
    MODE_LOOKUP, MODE_INSERT, MODE_REMOVE, MODE_ALLOC
  } mode_t;

  typedef enum logic [2:0] {
    SEL_IDX, SEL_IDX_M1, SEL_IDX_P1, SEL_J_M1, SEL_J_P1, SEL_CNT_M1
  } rd_sel_t;

  typedef enum logic [5:0] {
    OP_NOP, OP_LOAD, OP_IDX_CLR, OP_IDX_INC, OP_FIDX_CLR, OP_FIDX_INC,
    OP_J_RCNT, OP_J_FCNT, OP_J_FIDX,
    OP_RSH_UP, OP_RSH_DN, OP_FSH_UP, OP_FSH_DN, OP_RDEL_END, OP_FDEL_END,
    OP_RINS_WR, OP_MRG_PREV, OP_MRG_NEXT,
    OP_RM_FULL, OP_RM_HEAD, OP_RM_TAIL, OP_RM_SPLIT, OP_SPLIT_HI, OP_SPLIT_LO,
    OP_FP_MERGE, OP_FINS_WR, OP_FC_MERGE, OP_CUR_POP,
    OP_A_FREEPICK, OP_A_CURPICK, OP_A_FTRIM, OP_A_CURSET,
    OP_FIN_FAIL, OP_FIN_OK, OP_FIN_FOUND, OP_FIN_ALLOC
  } dp_op_t;

  typedef struct packed {
    dp_op_t  op;
    rd_sel_t rsel;
    rd_sel_t fsel;
  } dp_cmd_t;

  typedef struct packed {
    logic idx_lt_rcnt;
    logic idx_zero;
    logic idxp1_lt_rcnt;
    logic j_gt_idx;
    logic jp1_lt_rcnt;
    logic rfull;
    logic fidx_lt_fcnt;
    logic fidx_zero;
    logic fidxp1_lt_fcnt;
    logic j_gt_fidx;
    logic jp1_lt_fcnt;
    logic ffull;
    logic fcnt_zero;
    logic s_ge_e;
    logic size_zero;
    logic s_lt_rs;
    logic s_lt_re;
    logic rs_lt_s;
    logic e_gt_rs;
    logic e_le_rs;
    logic s_ge_re;
    logic s_le_rs;
    logic e_ge_re;
    logic prev_merge;
    logic next_merge;
    logic kd_free;
    logic fs_ge_fe;
    logic fst_lt_fs;
    logic fend_ge_fs;
    logic fe_ge_fst;
    logic fend_eq_cur;
    logic fsize_lt_sp;
    logic cursor_bad;
    logic lim_bad;
    logic top_bad;
    logic base_eq_fs;
  } dp_stat_t;

  typedef enum logic [5:0] {
    S_IDLE, S_LK_RD, S_LK_CHK,
    S_IN_START, S_IN_SCAN, S_IN_SCN2, S_IN_PREV, S_IN_PREV2, S_IN_SH, S_IN_SH2,
    S_IN_MP, S_IN_MP2, S_IN_MN, S_IN_MN2, S_IN_DONE,
    S_RD_LOOP, S_RD_2,
    S_RM_START, S_RM_SCAN, S_RM_CHK, S_SP_SH, S_SP_SH2, S_SP_LO, S_RM_FREE,
    S_FR_SCAN, S_FR_S2, S_FR_P, S_FR_P2, S_FR_INS, S_FR_SH, S_FR_SH2,
    S_FR_CO, S_FR_CO2, S_FR_CU, S_FR_CU2, S_FD_LOOP, S_FD_2,
    S_AL_START, S_AL_SCAN, S_AL_S2, S_AL_CUR, S_AL_LIM, S_AL_FPOST, S_AL_CPOST,
    S_AL_FIN
  } state_t;

endpackage

// File: sv/rta_ctrl.sv
module rta_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [1:0]       in_mode,
  input  rta_pkg::dp_stat_t stat,
  output rta_pkg::dp_cmd_t  cmd,
  output logic             busy
);
  import rta_pkg::*;

  state_t state_r, state_nxt;
  state_t ret_r, ret_nxt;
  mode_t  mode_r, mode_nxt;
  logic   afree_r, afree_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ret_r   <= S_IDLE;
      mode_r  <= MODE_LOOKUP;
      afree_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
      mode_r  <= mode_nxt;
      afree_r <= afree_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    mode_nxt  = mode_r;
    afree_nxt = afree_r;
    cmd.op    = OP_NOP;
    cmd.rsel  = SEL_IDX;
    cmd.fsel  = SEL_IDX;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.op   = OP_LOAD;
          mode_nxt = mode_t'(in_mode);
          case (mode_t'(in_mode))
            MODE_LOOKUP: state_nxt = S_LK_RD;
            MODE_INSERT: state_nxt = S_IN_START;
            MODE_REMOVE: state_nxt = S_RM_START;
            default:     state_nxt = S_AL_START;
          endcase
        end
      end
      // lookup
      S_LK_RD: begin
        if (!stat.idx_lt_rcnt) begin
          cmd.op = OP_FIN_FAIL; state_nxt = S_IDLE;
        end else begin
          cmd.rsel = SEL_IDX; state_nxt = S_LK_CHK;
        end
      end
      S_LK_CHK: begin
        if (stat.s_lt_rs) begin
          cmd.op = OP_FIN_FAIL; state_nxt = S_IDLE;
        end else if (stat.s_lt_re) begin
          cmd.op = OP_FIN_FOUND; state_nxt = S_IDLE;
        end else begin
          cmd.op = OP_IDX_INC; state_nxt = S_LK_RD;
        end
      end
      // insert
      S_IN_START: begin
        if (stat.s_ge_e || stat.rfull) begin
          cmd.op = OP_FIN_FAIL; state_nxt = S_IDLE;
        end else begin
          cmd.op = OP_IDX_CLR; state_nxt = S_IN_SCAN;
        end
      end
      S_IN_SCAN: begin
        if (!stat.idx_lt_rcnt) begin
          state_nxt = S_IN_PREV;
        end else begin
          cmd.rsel = SEL_IDX; state_nxt = S_IN_SCN2;
        end
      end
      S_IN_SCN2: begin
        if (stat.rs_lt_s) begin
          cmd.op = OP_IDX_INC; state_nxt = S_IN_SCAN;
        end else if (stat.e_gt_rs) begin
          cmd.op = OP_FIN_FAIL; state_nxt = S_IDLE;
        end else begin
          state_nxt = S_IN_PREV;
        end
      end
      S_IN_PREV: begin
        if (stat.idx_zero) begin
          cmd.op = OP_J_RCNT; state_nxt = S_IN_SH;
        end else begin
          cmd.rsel = SEL_IDX_M1; state_nxt = S_IN_PREV2;
        end
      end
      S_IN_PREV2: begin
        if (stat.s_lt_re) begin
          cmd.op = OP_FIN_FAIL; state_nxt = S_IDLE;
        end else begin
          cmd.op = OP_J_RCNT; state_nxt = S_IN_SH;
        end
      end
      S_IN_SH: begin
        if (stat.j_gt_idx) begin
          cmd.rsel = SEL_J_M1; state_nxt = S_IN_SH2;
        end else begin
          cmd.op = OP_RINS_WR; state_nxt = S_IN_MP;
        end
      end
      S_IN_SH2: begin
        cmd.op = OP_RSH_UP; state_nxt = S_IN_SH;
      end
      S_IN_MP: begin
        if (stat.idx_zero) begin
          state_nxt = S_IN_MN;
        end else begin
          cmd.rsel = SEL_IDX_M1; state_nxt = S_IN_MP2;
        end
      end
      S_IN_MP2: begin
        if (stat.prev_merge) begin
          cmd.op = OP_MRG_PREV; ret_nxt = S_IN_MN; state_nxt = S_RD_LOOP;
        end else begin
          state_nxt = S_IN_MN;
        end
      end
      S_IN_MN: begin
        if (stat.idxp1_lt_rcnt) begin
          cmd.rsel = SEL_IDX_P1; state_nxt = S_IN_MN2;
        end else begin
          state_nxt = S_IN_DONE;
        end
      end
      S_IN_MN2: begin
        if (stat.next_merge) begin
          cmd.op = OP_MRG_NEXT; ret_nxt = S_IN_DONE; state_nxt = S_RD_LOOP;
        end else begin
          state_nxt = S_IN_DONE;
        end
      end
      S_IN_DONE: begin
        if (mode_r == MODE_INSERT) begin
          cmd.op = OP_FIN_OK; state_nxt = S_IDLE;
        end else if (afree_r) begin
          state_nxt = S_AL_FPOST;
        end else begin
          state_nxt = S_AL_CPOST;
        end
      end
      // region delete
      S_RD_LOOP: begin
        if (stat.jp1_lt_rcnt) begin
          cmd.rsel = SEL_J_P1; state_nxt = S_RD_2;
        end else begin
          cmd.op = OP_RDEL_END; state_nxt = ret_r;
        end
      end
      S_RD_2: begin
        cmd.op = OP_RSH_DN; state_nxt = S_RD_LOOP;
      end
      // remove
      S_RM_START: begin
        if (stat.s_ge_e) begin
          cmd.op = OP_FIN_FAIL; state_nxt = S_IDLE;
        end else begin
          state_nxt = S_RM_SCAN;
        end
      end
      S_RM_SCAN: begin
        if (!stat.idx_lt_rcnt) begin
          cmd.op = OP_FIN_FAIL; state_nxt = S_IDLE;
        end else begin
          cmd.rsel = SEL_IDX; state_nxt = S_RM_CHK;
        end
      end
      S_RM_CHK: begin
        if (stat.e_le_rs) begin
          cmd.op = OP_FIN_FAIL; state_nxt = S_IDLE;
        end else if (stat.s_ge_re) begin
          cmd.op = OP_IDX_INC; state_nxt = S_RM_SCAN;
        end else if (stat.s_le_rs && stat.e_ge_re) begin
          cmd.op = OP_RM_FULL; ret_nxt = S_RM_FREE; state_nxt = S_RD_LOOP;
        end else if (stat.s_le_rs) begin
          cmd.op = OP_RM_HEAD; state_nxt = S_RM_FREE;
        end else if (stat.e_ge_re) begin
          cmd.op = OP_RM_TAIL; state_nxt = S_RM_FREE;
        end else if (stat.rfull) begin
          cmd.op = OP_FIN_FAIL; state_nxt = S_IDLE;
        end else begin
          cmd.op = OP_RM_SPLIT; state_nxt = S_SP_SH;
        end
      end
      S_SP_SH: begin
        if (stat.j_gt_idx) begin
          cmd.rsel = SEL_J_M1; state_nxt = S_SP_SH2;
        end else begin
          cmd.op = OP_SPLIT_HI; state_nxt = S_SP_LO;
        end
      end
      S_SP_SH2: begin
        cmd.op = OP_RSH_UP; state_nxt = S_SP_SH;
      end
      S_SP_LO: begin
        cmd.op = OP_SPLIT_LO; state_nxt = S_RM_FREE;
      end
      S_RM_FREE: begin
        if (!stat.kd_free || stat.fs_ge_fe) begin
          cmd.op = OP_FIN_OK; state_nxt = S_IDLE;
        end else begin
          cmd.op = OP_FIDX_CLR; state_nxt = S_FR_SCAN;
        end
      end
      // free range record
      S_FR_SCAN: begin
        if (!stat.fidx_lt_fcnt) begin
          state_nxt = S_FR_P;
        end else begin
          cmd.fsel = SEL_IDX; state_nxt = S_FR_S2;
        end
      end
      S_FR_S2: begin
        if (stat.fst_lt_fs) begin
          cmd.op = OP_FIDX_INC; state_nxt = S_FR_SCAN;
        end else begin
          state_nxt = S_FR_P;
        end
      end
      S_FR_P: begin
        if (stat.fidx_zero) begin
          state_nxt = S_FR_INS;
        end else begin
          cmd.fsel = SEL_IDX_M1; state_nxt = S_FR_P2;
        end
      end
      S_FR_P2: begin
        if (stat.fend_ge_fs) begin
          cmd.op = OP_FP_MERGE; state_nxt = S_FR_CO;
        end else begin
          state_nxt = S_FR_INS;
        end
      end
      S_FR_INS: begin
        if (stat.ffull) begin
          cmd.op = OP_FIN_OK; state_nxt = S_IDLE;
        end else begin
          cmd.op = OP_J_FCNT; state_nxt = S_FR_SH;
        end
      end
      S_FR_SH: begin
        if (stat.j_gt_fidx) begin
          cmd.fsel = SEL_J_M1; state_nxt = S_FR_SH2;
        end else begin
          cmd.op = OP_FINS_WR; state_nxt = S_FR_CO;
        end
      end
      S_FR_SH2: begin
        cmd.op = OP_FSH_UP; state_nxt = S_FR_SH;
      end
      S_FR_CO: begin
        if (stat.fidxp1_lt_fcnt) begin
          cmd.fsel = SEL_IDX_P1; state_nxt = S_FR_CO2;
        end else begin
          state_nxt = S_FR_CU;
        end
      end
      S_FR_CO2: begin
        if (stat.fe_ge_fst) begin
          cmd.op = OP_FC_MERGE; ret_nxt = S_FR_CO; state_nxt = S_FD_LOOP;
        end else begin
          state_nxt = S_FR_CU;
        end
      end
      S_FR_CU: begin
        if (stat.fcnt_zero) begin
          cmd.op = OP_FIN_OK; state_nxt = S_IDLE;
        end else begin
          cmd.fsel = SEL_CNT_M1; state_nxt = S_FR_CU2;
        end
      end
      S_FR_CU2: begin
        if (stat.fend_eq_cur) begin
          cmd.op = OP_CUR_POP; state_nxt = S_FR_CU;
        end else begin
          cmd.op = OP_FIN_OK; state_nxt = S_IDLE;
        end
      end
      // free delete
      S_FD_LOOP: begin
        if (stat.jp1_lt_fcnt) begin
          cmd.fsel = SEL_J_P1; state_nxt = S_FD_2;
        end else begin
          cmd.op = OP_FDEL_END; state_nxt = ret_r;
        end
      end
      S_FD_2: begin
        cmd.op = OP_FSH_DN; state_nxt = S_FD_LOOP;
      end
      // allocate
      S_AL_START: begin
        if (stat.size_zero) begin
          cmd.op = OP_FIN_FAIL; state_nxt = S_IDLE;
        end else begin
          cmd.op = OP_FIDX_CLR; state_nxt = S_AL_SCAN;
        end
      end
      S_AL_SCAN: begin
        if (!stat.fidx_lt_fcnt) begin
          state_nxt = S_AL_CUR;
        end else begin
          cmd.fsel = SEL_IDX; state_nxt = S_AL_S2;
        end
      end
      S_AL_S2: begin
        if (stat.fsize_lt_sp) begin
          cmd.op = OP_FIDX_INC; state_nxt = S_AL_SCAN;
        end else begin
          cmd.op = OP_A_FREEPICK; afree_nxt = 1'b1; state_nxt = S_IN_START;
        end
      end
      S_AL_CUR: begin
        if (stat.cursor_bad) begin
          cmd.op = OP_FIN_FAIL; state_nxt = S_IDLE;
        end else begin
          cmd.op = OP_A_CURPICK; afree_nxt = 1'b0; state_nxt = S_AL_LIM;
        end
      end
      S_AL_LIM: begin
        if (stat.lim_bad || stat.top_bad) begin
          cmd.op = OP_FIN_FAIL; state_nxt = S_IDLE;
        end else begin
          state_nxt = S_IN_START;
        end
      end
      S_AL_FPOST: begin
        if (stat.base_eq_fs) begin
          cmd.op = OP_J_FIDX; ret_nxt = S_AL_FIN; state_nxt = S_FD_LOOP;
        end else begin
          cmd.op = OP_A_FTRIM; state_nxt = S_AL_FIN;
        end
      end
      S_AL_CPOST: begin
        cmd.op = OP_A_CURSET; state_nxt = S_AL_FIN;
      end
      S_AL_FIN: begin
        cmd.op = OP_FIN_ALLOC; state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// File: sv/rta_dp.sv
module rta_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  rta_pkg::dp_cmd_t                cmd,
  output rta_pkg::dp_stat_t               stat,
  input  logic [rta_pkg::ADDR_BITS-1:0]   in_addr_start,
  input  logic [rta_pkg::ADDR_BITS-1:0]   in_addr_end,
  input  logic [rta_pkg::ADDR_BITS-1:0]   in_size_bytes,
  input  logic [7:0]                      in_prot,
  input  logic [7:0]                      in_kind,
  input  logic [7:0]                      in_region_flags_in,
  input  logic                            cfg_we,
  input  logic [rta_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rta_pkg::ADDR_BITS-1:0]   cfg_wdata,
  output logic                            out_valid,
  output logic                            out_ok,
  output logic [rta_pkg::ADDR_BITS-1:0]   out_alloc_base,
  output logic [rta_pkg::ADDR_BITS-1:0]   out_found_start,
  output logic [rta_pkg::ADDR_BITS-1:0]   out_found_end,
  output logic [7:0]                      out_found_prot,
  output logic [7:0]                      out_found_kind,
  output logic [7:0]                      out_found_flags
);
  import rta_pkg::*;

  region_t rmem [MAX_REGIONS];
  free_t   fmem [MAX_REGIONS];
  region_t rq_r, cur_r;
  free_t   fq_r;

  logic [CNT_W-1:0]  rcnt_r, fcnt_r, idx_r, fidx_r, j_r;
  logic [PG_W-1:0]   s_r, e_r, fs_r, fe_r, base_r, cursor_r;
  logic [PG_W:0]     sp_r;
  logic              szero_r;
  logic [ATTR_W-1:0] attr_r;
  logic [CODE_W-1:0] kd_r;

  logic [ADDR_BITS-1:0] heap_break_r, mmap_top_r;
  logic [GUARD_W-1:0]   guard_r;
  logic [CODE_W-1:0]    heapk_r, stackk_r, nomerge_r;

  logic              ov_r, ook_r;
  logic [PG_W-1:0]   obase_r, ofs_r, ofe_r;
  logic [ATTR_W-1:0] oattr_r;

  logic [CNT_W-1:0]  ra, fa, rwa, fwa;
  logic              rwe, fwe;
  region_t           rwd;
  free_t             fwd;
  logic [PG_W-1:0]   fmax, pe, sub_free, sub_cur;
  logic [PG_W:0]     sp_in;
  logic [ADDR_BITS:0] lim;

  // read address select
  always_comb begin
    case (cmd.rsel)
      SEL_IDX:    ra = idx_r;
      SEL_IDX_M1: ra = idx_r - 1'b1;
      SEL_IDX_P1: ra = idx_r + 1'b1;
      SEL_J_M1:   ra = j_r - 1'b1;
      SEL_J_P1:   ra = j_r + 1'b1;
      default:    ra = rcnt_r - 1'b1;
    endcase
    case (cmd.fsel)
      SEL_IDX:    fa = fidx_r;
      SEL_IDX_M1: fa = fidx_r - 1'b1;
      SEL_IDX_P1: fa = fidx_r + 1'b1;
      SEL_J_M1:   fa = j_r - 1'b1;
      SEL_J_P1:   fa = j_r + 1'b1;
      default:    fa = fcnt_r - 1'b1;
    endcase
  end

  assign fmax     = (fq_r.pg_end > fe_r) ? fq_r.pg_end : fe_r;
  assign sub_free = fq_r.pg_end - sp_r[PG_W-1:0];
  assign sub_cur  = cursor_r - sp_r[PG_W-1:0];

  // write port select
  always_comb begin
    rwe = 1'b0;
    rwa = idx_r;
    rwd = rq_r;
    fwe = 1'b0;
    fwa = fidx_r;
    fwd = fq_r;
    case (cmd.op)
      OP_RSH_UP, OP_RSH_DN: begin
        rwe = 1'b1; rwa = j_r;
      end
      OP_RINS_WR: begin
        rwe = 1'b1; rwd = '{s_r, e_r, attr_r};
      end
      OP_MRG_PREV: begin
        rwe = 1'b1; rwa = idx_r - 1'b1; rwd = '{rq_r.pg_start, e_r, rq_r.attr};
      end
      OP_MRG_NEXT: begin
        rwe = 1'b1; rwd = '{s_r, rq_r.pg_end, attr_r};
      end
      OP_RM_HEAD: begin
        rwe = 1'b1; rwd = '{e_r, rq_r.pg_end, rq_r.attr};
      end
      OP_RM_TAIL: begin
        rwe = 1'b1; rwd = '{rq_r.pg_start, s_r, rq_r.attr};
      end
      OP_SPLIT_HI: begin
        rwe = 1'b1; rwd = '{e_r, cur_r.pg_end, cur_r.attr};
      end
      OP_SPLIT_LO: begin
        rwe = 1'b1; rwa = idx_r - 1'b1; rwd = '{cur_r.pg_start, s_r, cur_r.attr};
      end
      OP_FSH_UP, OP_FSH_DN: begin
        fwe = 1'b1; fwa = j_r;
      end
      OP_FP_MERGE: begin
        fwe = 1'b1; fwa = fidx_r - 1'b1; fwd = '{fq_r.pg_start, fmax};
      end
      OP_FINS_WR: begin
        fwe = 1'b1; fwd = '{fs_r, fe_r};
      end
      OP_FC_MERGE: begin
        fwe = 1'b1; fwd = '{fs_r, fmax};
      end
      OP_A_FTRIM: begin
        fwe = 1'b1; fwd = '{fs_r, base_r};
      end
      default: begin
        rwe = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rwe) rmem[rwa[IDX_W-1:0]] <= rwd;
    if (fwe) fmem[fwa[IDX_W-1:0]] <= fwd;
    rq_r <= rmem[ra[IDX_W-1:0]];
    fq_r <= fmem[fa[IDX_W-1:0]];
  end

  // page rounding of the range end, saturating at the top page, and of the size up to whole pages
  always_comb begin
    pe = in_addr_end[ADDR_BITS-1:PAGE_BITS];
    if ((in_addr_end[PAGE_BITS-1:0] != '0) && (pe != '1)) pe = pe + 1'b1;
    sp_in = {1'b0, in_size_bytes[ADDR_BITS-1:PAGE_BITS]}
            + (PG_W+1)'(in_size_bytes[PAGE_BITS-1:0] != '0);
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rcnt_r       <= '0;
      fcnt_r       <= '0;
      cursor_r     <= '0;
      heap_break_r <= '0;
      mmap_top_r   <= '0;
      guard_r      <= GUARD_RST;
      heapk_r      <= HEAP_KIND_RST;
      stackk_r     <= STACK_KIND_RST;
      nomerge_r    <= NO_MERGE_RST;
      ov_r         <= 1'b0;
    end else begin
      ov_r <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          CFG_HEAP_BREAK: heap_break_r <= cfg_wdata;
          CFG_MMAP_TOP: begin
            mmap_top_r <= cfg_wdata;
            cursor_r   <= cfg_wdata[ADDR_BITS-1:PAGE_BITS];
          end
          CFG_GUARD:      guard_r   <= cfg_wdata[GUARD_W-1:0];
          CFG_HEAP_KIND:  heapk_r   <= cfg_wdata[CODE_W-1:0];
          CFG_STACK_KIND: stackk_r  <= cfg_wdata[CODE_W-1:0];
          CFG_NO_MERGE:   nomerge_r <= cfg_wdata[CODE_W-1:0];
          default: ;
        endcase
      end
      case (cmd.op)
        OP_RDEL_END:             rcnt_r   <= rcnt_r - 1'b1;
        OP_RINS_WR, OP_SPLIT_HI: rcnt_r   <= rcnt_r + 1'b1;
        OP_FDEL_END:             fcnt_r   <= fcnt_r - 1'b1;
        OP_FINS_WR:              fcnt_r   <= fcnt_r + 1'b1;
        OP_CUR_POP: begin
          cursor_r <= fq_r.pg_start;
          fcnt_r   <= fcnt_r - 1'b1;
        end
        OP_A_CURSET:             cursor_r <= base_r;
        OP_FIN_FAIL, OP_FIN_OK, OP_FIN_FOUND, OP_FIN_ALLOC: ov_r <= 1'b1;
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        s_r     <= in_addr_start[ADDR_BITS-1:PAGE_BITS];
        e_r     <= pe;
        attr_r  <= {in_region_flags_in, in_kind, in_prot};
        sp_r    <= sp_in;
        szero_r <= (in_size_bytes == '0);
        idx_r   <= '0;
        fidx_r  <= '0;
      end
      OP_IDX_CLR:  idx_r  <= '0;
      OP_IDX_INC:  idx_r  <= idx_r + 1'b1;
      OP_FIDX_CLR: fidx_r <= '0;
      OP_FIDX_INC: fidx_r <= fidx_r + 1'b1;
      OP_J_RCNT:   j_r    <= rcnt_r;
      OP_J_FCNT:   j_r    <= fcnt_r;
      OP_J_FIDX:   j_r    <= fidx_r;
      OP_RSH_UP, OP_FSH_UP: j_r <= j_r - 1'b1;
      OP_RSH_DN, OP_FSH_DN: j_r <= j_r + 1'b1;
      OP_MRG_PREV: begin
        s_r   <= rq_r.pg_start;
        j_r   <= idx_r;
        idx_r <= idx_r - 1'b1;
      end
      OP_MRG_NEXT: begin
        e_r <= rq_r.pg_end;
        j_r <= idx_r + 1'b1;
      end
      OP_RM_FULL: begin
        fs_r <= rq_r.pg_start;
        fe_r <= rq_r.pg_end;
        kd_r <= rq_r.attr[15:8];
        j_r  <= idx_r;
      end
      OP_RM_HEAD: begin
        fs_r <= rq_r.pg_start;
        fe_r <= e_r;
        kd_r <= rq_r.attr[15:8];
      end
      OP_RM_TAIL: begin
        fs_r <= s_r;
        fe_r <= rq_r.pg_end;
        kd_r <= rq_r.attr[15:8];
      end
      OP_RM_SPLIT: begin
        fs_r  <= s_r;
        fe_r  <= e_r;
        kd_r  <= rq_r.attr[15:8];
        cur_r <= rq_r;
        idx_r <= idx_r + 1'b1;
        j_r   <= rcnt_r;
      end
      OP_FP_MERGE: begin
        fs_r   <= fq_r.pg_start;
        fe_r   <= fmax;
        fidx_r <= fidx_r - 1'b1;
      end
      OP_FC_MERGE: begin
        fe_r <= fmax;
        j_r  <= fidx_r + 1'b1;
      end
      OP_A_FREEPICK: begin
        s_r    <= sub_free;
        e_r    <= fq_r.pg_end;
        base_r <= sub_free;
        fs_r   <= fq_r.pg_start;
      end
      OP_A_CURPICK: begin
        s_r    <= sub_cur;
        e_r    <= cursor_r;
        base_r <= sub_cur;
      end
      OP_FIN_FAIL, OP_FIN_OK: begin
        ook_r   <= (cmd.op == OP_FIN_OK);
        obase_r <= '0;
        ofs_r   <= '0;
        ofe_r   <= '0;
        oattr_r <= '0;
      end
      OP_FIN_FOUND: begin
        ook_r   <= 1'b1;
        obase_r <= '0;
        ofs_r   <= rq_r.pg_start;
        ofe_r   <= rq_r.pg_end;
        oattr_r <= rq_r.attr;
      end
      OP_FIN_ALLOC: begin
        ook_r   <= 1'b1;
        obase_r <= base_r;
        ofs_r   <= '0;
        ofe_r   <= '0;
        oattr_r <= '0;
      end
      default: ;
    endcase
  end

  assign lim = {1'b0, heap_break_r}
             + (ADDR_BITS+1)'({guard_r, {PAGE_BITS{1'b0}}});

  always_comb begin
    stat.idx_lt_rcnt    = (idx_r < rcnt_r);
    stat.idx_zero       = (idx_r == '0);
    stat.idxp1_lt_rcnt  = ({1'b0, idx_r} + 1'b1) < {1'b0, rcnt_r};
    stat.j_gt_idx       = (j_r > idx_r);
    stat.jp1_lt_rcnt    = ({1'b0, j_r} + 1'b1) < {1'b0, rcnt_r};
    stat.rfull          = (rcnt_r >= CNT_W'(MAX_REGIONS));
    stat.fidx_lt_fcnt   = (fidx_r < fcnt_r);
    stat.fidx_zero      = (fidx_r == '0);
    stat.fidxp1_lt_fcnt = ({1'b0, fidx_r} + 1'b1) < {1'b0, fcnt_r};
    stat.j_gt_fidx      = (j_r > fidx_r);
    stat.jp1_lt_fcnt    = ({1'b0, j_r} + 1'b1) < {1'b0, fcnt_r};
    stat.ffull          = (fcnt_r >= CNT_W'(MAX_REGIONS));
    stat.fcnt_zero      = (fcnt_r == '0);
    stat.s_ge_e         = (s_r >= e_r);
    stat.size_zero      = szero_r;
    stat.s_lt_rs        = (s_r < rq_r.pg_start);
    stat.s_lt_re        = (s_r < rq_r.pg_end);
    stat.rs_lt_s        = (rq_r.pg_start < s_r);
    stat.e_gt_rs        = (e_r > rq_r.pg_start);
    stat.e_le_rs        = (e_r <= rq_r.pg_start);
    stat.s_ge_re        = (s_r >= rq_r.pg_end);
    stat.s_le_rs        = (s_r <= rq_r.pg_start);
    stat.e_ge_re        = (e_r >= rq_r.pg_end);
    stat.prev_merge     = (rq_r.pg_end == s_r) && (rq_r.attr == attr_r) &&
                          ((rq_r.attr[23:16] & nomerge_r) == '0);
    stat.next_merge     = (e_r == rq_r.pg_start) && (rq_r.attr == attr_r) &&
                          ((attr_r[23:16] & nomerge_r) == '0);
    stat.kd_free        = (kd_r != heapk_r) && (kd_r != stackk_r);
    stat.fs_ge_fe       = (fs_r >= fe_r);
    stat.fst_lt_fs      = (fq_r.pg_start < fs_r);
    stat.fend_ge_fs     = (fq_r.pg_end >= fs_r);
    stat.fe_ge_fst      = (fe_r >= fq_r.pg_start);
    stat.fend_eq_cur    = (fq_r.pg_end == cursor_r);
    stat.fsize_lt_sp    = {1'b0, fq_r.pg_end - fq_r.pg_start} < sp_r;
    stat.cursor_bad     = (cursor_r == '0) || (sp_r > {1'b0, cursor_r});
    stat.lim_bad        = {1'b0, base_r, {PAGE_BITS{1'b0}}} < lim;
    stat.top_bad        = {cursor_r, {PAGE_BITS{1'b0}}} > mmap_top_r;
    stat.base_eq_fs     = (base_r == fs_r);
  end

  assign out_valid       = ov_r;
  assign out_ok          = ook_r;
  assign out_alloc_base  = {obase_r, {PAGE_BITS{1'b0}}};
  assign out_found_start = {ofs_r, {PAGE_BITS{1'b0}}};
  assign out_found_end   = {ofe_r, {PAGE_BITS{1'b0}}};
  assign out_found_prot  = oattr_r[7:0];
  assign out_found_kind  = oattr_r[15:8];
  assign out_found_flags = oattr_r[23:16];

endmodule

// File: sv/region_table_allocator.sv
// lookup: scans the region table in order until it finds or passes the start page;
// insert, remove and allocate scan and shift table entries through the single read port
// of each table, so their run time grows with the number of entries scanned or shifted
// throughput: one operation at a time, set by the single read port of each table
// result strobe out_valid lasts one cycle; the receiver cannot stall
// synchronous reset empties both tables by clearing their counts, clears the cursor and loads register defaults
module region_table_allocator (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [1:0]                      in_mode,
  input  logic [rta_pkg::ADDR_BITS-1:0]   in_addr_start,
  input  logic [rta_pkg::ADDR_BITS-1:0]   in_addr_end,
  input  logic [rta_pkg::ADDR_BITS-1:0]   in_size_bytes,
  input  logic [7:0]                      in_prot,
  input  logic [7:0]                      in_kind,
  input  logic [7:0]                      in_region_flags_in,
  output logic                            out_valid,
  output logic                            out_ok,
  output logic [rta_pkg::ADDR_BITS-1:0]   out_alloc_base,
  output logic [rta_pkg::ADDR_BITS-1:0]   out_found_start,
  output logic [rta_pkg::ADDR_BITS-1:0]   out_found_end,
  output logic [7:0]                      out_found_prot,
  output logic [7:0]                      out_found_kind,
  output logic [7:0]                      out_found_flags,
  input  logic                            cfg_we,
  input  logic [rta_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rta_pkg::ADDR_BITS-1:0]   cfg_wdata
);
  import rta_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  rta_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_mode (in_mode),
    .stat    (stat),
    .cmd     (cmd),
    .busy    (busy)
  );

  rta_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .in_addr_start      (in_addr_start),
    .in_addr_end        (in_addr_end),
    .in_size_bytes      (in_size_bytes),
    .in_prot            (in_prot),
    .in_kind            (in_kind),
    .in_region_flags_in (in_region_flags_in),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .out_valid          (out_valid),
    .out_ok             (out_ok),
    .out_alloc_base     (out_alloc_base),
    .out_found_start    (out_found_start),
    .out_found_end      (out_found_end),
    .out_found_prot     (out_found_prot),
    .out_found_kind     (out_found_kind),
    .out_found_flags    (out_found_flags)
  );

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import rta_pkg::*;

  typedef bit [63:0] u64;

  typedef struct {
    mode_t       mode;
    bit [47:0]   a_start;
    bit [47:0]   a_end;
    bit [47:0]   size;
    bit [7:0]    prot;
    bit [7:0]    kind;
    bit [7:0]    flags;
  } op_t;

  typedef struct {
    bit        ok;
    bit [47:0] base;
    bit [47:0] f_start;
    bit [47:0] f_end;
    bit [7:0]  f_prot;
    bit [7:0]  f_kind;
    bit [7:0]  f_flags;
  } outcome_t;

  localparam u64 PG_TOP = (64'd1 << PG_W) - 1;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic [1:0]           in_mode = '0;
  logic [ADDR_BITS-1:0] in_addr_start = '0;
  logic [ADDR_BITS-1:0] in_addr_end = '0;
  logic [ADDR_BITS-1:0] in_size_bytes = '0;
  logic [7:0]           in_prot = '0;
  logic [7:0]           in_kind = '0;
  logic [7:0]           in_region_flags_in = '0;
  logic                 out_valid;
  logic                 out_ok;
  logic [ADDR_BITS-1:0] out_alloc_base;
  logic [ADDR_BITS-1:0] out_found_start;
  logic [ADDR_BITS-1:0] out_found_end;
  logic [7:0]           out_found_prot;
  logic [7:0]           out_found_kind;
  logic [7:0]           out_found_flags;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [ADDR_BITS-1:0] cfg_wdata = '0;

  region_table_allocator u_dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // shadow of the region table, free list, cursor and registers
  bit [PG_W-1:0]   reg_s[MAX_REGIONS];
  bit [PG_W-1:0]   reg_e[MAX_REGIONS];
  bit [ATTR_W-1:0] reg_a[MAX_REGIONS];
  int              reg_n = 0;
  bit [PG_W-1:0]   fr_s[MAX_REGIONS];
  bit [PG_W-1:0]   fr_e[MAX_REGIONS];
  int              fr_n = 0;
  u64              cursor = 0;
  u64              heap_brk = 0;
  u64              mm_top = 0;
  u64              guard = GUARD_RST;
  bit [7:0]        heap_code = HEAP_KIND_RST;
  bit [7:0]        stack_code = STACK_KIND_RST;
  bit [7:0]        merge_mask = NO_MERGE_RST;

  op_t      pend_q[$];
  outcome_t outcome_q[$];
  int       errors = 0;
  bit       no_gaps = 0;

  function automatic u64 page_ceil(bit [47:0] a);
    u64 p;
    p = u64'(a) >> PAGE_BITS;
    if (a[PAGE_BITS-1:0] != 0 && p < PG_TOP) p++;
    return p;
  endfunction

  function automatic void reg_drop(int k);
    for (int j = k; j + 1 < reg_n; j++) begin
      reg_s[j] = reg_s[j+1];
      reg_e[j] = reg_e[j+1];
      reg_a[j] = reg_a[j+1];
    end
    reg_n--;
  endfunction

  function automatic bit mergeable(int a);
    return reg_e[a] == reg_s[a+1] && reg_a[a] == reg_a[a+1] &&
           (reg_a[a][23:16] & merge_mask) == 0;
  endfunction

  function automatic bit reg_add(u64 s, u64 e, bit [23:0] attr);
    int ins;
    ins = 0;
    if (s >= e || reg_n >= MAX_REGIONS) return 0;
    while (ins < reg_n && reg_s[ins] < s) ins++;
    if (ins > 0 && s < reg_e[ins-1]) return 0;
    if (ins < reg_n && e > reg_s[ins]) return 0;
    for (int i = reg_n; i > ins; i--) begin
      reg_s[i] = reg_s[i-1];
      reg_e[i] = reg_e[i-1];
      reg_a[i] = reg_a[i-1];
    end
    reg_s[ins] = s;
    reg_e[ins] = e;
    reg_a[ins] = attr;
    reg_n++;
    if (ins > 0 && mergeable(ins - 1)) begin
      reg_e[ins-1] = reg_e[ins];
      reg_drop(ins);
      ins--;
    end
    if (ins + 1 < reg_n && mergeable(ins)) begin
      reg_e[ins] = reg_e[ins+1];
      reg_drop(ins + 1);
    end
    return 1;
  endfunction

  function automatic void fr_drop(int k);
    for (int j = k; j + 1 < fr_n; j++) begin
      fr_s[j] = fr_s[j+1];
      fr_e[j] = fr_e[j+1];
    end
    fr_n--;
  endfunction

  function automatic void fr_add(u64 s, u64 e);
    int ins;
    ins = 0;
    if (s >= e) return;
    while (ins < fr_n && fr_s[ins] < s) ins++;
    if (ins > 0 && fr_e[ins-1] >= s) begin
      if (fr_e[ins-1] < e) fr_e[ins-1] = e;
      ins--;
    end else begin
      if (fr_n >= MAX_REGIONS) return;
      for (int j = fr_n; j > ins; j--) begin
        fr_s[j] = fr_s[j-1];
        fr_e[j] = fr_e[j-1];
      end
      fr_s[ins] = s;
      fr_e[ins] = e;
      fr_n++;
    end
    while (ins + 1 < fr_n && fr_e[ins] >= fr_s[ins+1]) begin
      if (fr_e[ins] < fr_e[ins+1]) fr_e[ins] = fr_e[ins+1];
      fr_drop(ins + 1);
    end
    while (fr_n > 0 && u64'(fr_e[fr_n-1]) == cursor) begin
      cursor = fr_s[fr_n-1];
      fr_n--;
    end
  endfunction

  function automatic bit reg_cut(u64 s, u64 e);
    bit [7:0] kd;
    u64       fs, fe;
    if (s >= e) return 0;
    for (int i = 0; i < reg_n; i++) begin
      if (e <= reg_s[i]) return 0;
      if (s >= reg_e[i]) continue;
      kd = reg_a[i][15:8];
      if (s <= reg_s[i] && e >= reg_e[i]) begin
        fs = reg_s[i];
        fe = reg_e[i];
        reg_drop(i);
      end else if (s <= reg_s[i]) begin
        fs = reg_s[i];
        fe = e;
        reg_s[i] = e;
      end else if (e >= reg_e[i]) begin
        fs = s;
        fe = reg_e[i];
        reg_e[i] = s;
      end else begin
        if (reg_n >= MAX_REGIONS) return 0;
        fs = s;
        fe = e;
        for (int j = reg_n; j > i + 1; j--) begin
          reg_s[j] = reg_s[j-1];
          reg_e[j] = reg_e[j-1];
          reg_a[j] = reg_a[j-1];
        end
        reg_s[i+1] = e;
        reg_e[i+1] = reg_e[i];
        reg_a[i+1] = reg_a[i];
        reg_e[i] = s;
        reg_n++;
      end
      if (kd != heap_code && kd != stack_code) fr_add(fs, fe);
      return 1;
    end
    return 0;
  endfunction

  function automatic bit carve(bit [47:0] size, bit [23:0] attr, output u64 base);
    u64 sp, lim;
    base = 0;
    if (size == 0) return 0;
    sp = (u64'(size) >> PAGE_BITS) + (size[PAGE_BITS-1:0] != 0);
    for (int i = 0; i < fr_n; i++) begin
      if (u64'(fr_e[i]) - u64'(fr_s[i]) < sp) continue;
      base = u64'(fr_e[i]) - sp;
      if (!reg_add(base, base + sp, attr)) begin
        base = 0;
        return 0;
      end
      if (base == fr_s[i]) fr_drop(i);
      else fr_e[i] = base;
      return 1;
    end
    base = 0;
    if (cursor == 0 || sp > cursor) return 0;
    lim = heap_brk + (guard << PAGE_BITS);
    if (((cursor - sp) << PAGE_BITS) < lim) return 0;
    if ((cursor << PAGE_BITS) > mm_top) return 0;
    if (!reg_add(cursor - sp, cursor, attr)) return 0;
    cursor = cursor - sp;
    base = cursor;
    return 1;
  endfunction

  function automatic outcome_t apply_op(op_t op);
    outcome_t  r;
    u64        s, e, b;
    bit [23:0] attr;
    r = '{default: 0};
    s = u64'(op.a_start) >> PAGE_BITS;
    e = page_ceil(op.a_end);
    attr = {op.flags, op.kind, op.prot};
    case (op.mode)
      MODE_LOOKUP: begin
        for (int i = 0; i < reg_n; i++) begin
          if (s < reg_s[i]) break;
          if (s < reg_e[i]) begin
            r.ok = 1;
            r.f_start = 48'(u64'(reg_s[i]) << PAGE_BITS);
            r.f_end = 48'(u64'(reg_e[i]) << PAGE_BITS);
            {r.f_flags, r.f_kind, r.f_prot} = reg_a[i];
            break;
          end
        end
      end
      MODE_INSERT: r.ok = reg_add(s, e, attr);
      MODE_REMOVE: r.ok = reg_cut(s, e);
      default: begin
        r.ok = carve(op.size, attr, b);
        if (r.ok) r.base = 48'(b << PAGE_BITS);
      end
    endcase
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    op_t nxt;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        nxt.mode = mode_t'(in_mode);
        nxt.a_start = in_addr_start;
        nxt.a_end = in_addr_end;
        nxt.size = in_size_bytes;
        nxt.prot = in_prot;
        nxt.kind = in_kind;
        nxt.flags = in_region_flags_in;
        outcome_q.push_back(apply_op(nxt));
      end
      if (!(start && busy)) begin
        if (pend_q.size() > 0 && (no_gaps || $urandom_range(0, 99) >= 23)) begin
          nxt = pend_q.pop_front();
          in_mode <= nxt.mode;
          in_addr_start <= nxt.a_start;
          in_addr_end <= nxt.a_end;
          in_size_bytes <= nxt.size;
          in_prot <= nxt.prot;
          in_kind <= nxt.kind;
          in_region_flags_in <= nxt.flags;
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  task automatic report(string what, u64 got, u64 want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // monitor
  always @(posedge clk) begin
    outcome_t w;
    if (rst_n && out_valid) begin
      if (outcome_q.size() == 0) begin
        report("unexpected beat", out_ok, 0);
      end else begin
        w = outcome_q.pop_front();
        if (out_ok !== w.ok) report("ok", out_ok, w.ok);
        if (out_alloc_base !== w.base) report("alloc_base", out_alloc_base, w.base);
        if (out_found_start !== w.f_start) report("found_start", out_found_start, w.f_start);
        if (out_found_end !== w.f_end) report("found_end", out_found_end, w.f_end);
        if (out_found_prot !== w.f_prot) report("found_prot", out_found_prot, w.f_prot);
        if (out_found_kind !== w.f_kind) report("found_kind", out_found_kind, w.f_kind);
        if (out_found_flags !== w.f_flags) report("found_flags", out_found_flags, w.f_flags);
      end
    end
  end

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, bit [47:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_HEAP_BREAK: heap_brk = val;
      CFG_MMAP_TOP: begin
        mm_top = val;
        cursor = u64'(val) >> PAGE_BITS;
      end
      CFG_GUARD: guard = val[15:0];
      CFG_HEAP_KIND: heap_code = val[7:0];
      CFG_STACK_KIND: stack_code = val[7:0];
      CFG_NO_MERGE: merge_mask = val[7:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    while (pend_q.size() > 0 || start || outcome_q.size() > 0) @(posedge clk);
  endtask

  function automatic op_t mk(mode_t m, u64 s_pg, u64 e_pg, u64 size,
                             bit [7:0] p, bit [7:0] k, bit [7:0] f);
    op_t o;
    o.mode = m;
    o.a_start = 48'(s_pg << PAGE_BITS);
    o.a_end = 48'(e_pg << PAGE_BITS);
    o.size = 48'(size);
    o.prot = p;
    o.kind = k;
    o.flags = f;
    return o;
  endfunction

  function automatic op_t rand_op(u64 win);
    op_t o;
    u64  s_pg;
    int  pick;
    pick = $urandom_range(0, 99);
    o.mode = pick < 25 ? MODE_LOOKUP : pick < 55 ? MODE_INSERT :
             pick < 80 ? MODE_REMOVE : MODE_ALLOC;
    s_pg = win + $urandom_range(0, 320);
    o.a_start = 48'(s_pg << PAGE_BITS);
    if ($urandom_range(0, 1)) o.a_start[PAGE_BITS-1:0] = PAGE_BITS'($urandom());
    o.a_end = 48'((s_pg + $urandom_range(0, 12) - ($urandom_range(0, 15) == 0)) << PAGE_BITS);
    if ($urandom_range(0, 2) == 0) o.a_end[PAGE_BITS-1:0] = PAGE_BITS'($urandom());
    pick = $urandom_range(0, 99);
    if (pick < 5) o.size = '0;
    else if (pick < 10) o.size = 48'({$urandom(), $urandom()});
    else o.size = 48'($urandom_range(1, 8) * 4096 - $urandom_range(0, 4095));
    o.prot = 8'($urandom_range(0, 2));
    pick = $urandom_range(0, 5);
    o.kind = pick == 0 ? heap_code : pick == 1 ? stack_code : pick < 4 ? 8'd5 : 8'($urandom());
    o.flags = $urandom_range(0, 9) == 0 ? 8'($urandom()) : 8'($urandom_range(0, 3));
    if ($urandom_range(0, 32) == 0) begin
      o.a_start = 48'({$urandom(), $urandom()});
      o.a_end = 48'({$urandom(), $urandom()});
      o.prot = 8'($urandom());
      o.kind = 8'($urandom());
    end
    return o;
  endfunction

  task automatic run_phase(u64 win, int n, bit with_sweep);
    if (with_sweep)
      repeat (70) pend_q.push_back(mk(MODE_REMOVE, 0, PG_TOP, 0, 0, 5, 0));
    repeat (n) pend_q.push_back(rand_op(win));
    drain();
  endtask

  initial begin
    u64 w;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    w = 64'h10000;
    cfg_write(CFG_HEAP_BREAK, 48'(w << PAGE_BITS));
    cfg_write(CFG_MMAP_TOP, 48'((w + 400) << PAGE_BITS));
    // directed: merge, overlap, empty range, split/trim/delete, allocate edges
    pend_q.push_back(mk(MODE_LOOKUP, w, 0, 0, 0, 0, 0));
    pend_q.push_back(mk(MODE_INSERT, w, w + 4, 0, 3, 5, 0));
    pend_q.push_back(mk(MODE_INSERT, w + 4, w + 8, 0, 3, 5, 0));
    pend_q.push_back(mk(MODE_LOOKUP, w + 6, 0, 0, 0, 0, 0));
    pend_q.push_back(mk(MODE_INSERT, w + 2, w + 10, 0, 3, 5, 0));
    pend_q.push_back(mk(MODE_INSERT, w + 20, w + 20, 0, 3, 5, 0));
    pend_q.push_back(mk(MODE_INSERT, w + 8, w + 12, 0, 3, 5, 8'h01));
    pend_q.push_back(mk(MODE_REMOVE, w + 2, w + 3, 0, 0, 0, 0));
    pend_q.push_back(mk(MODE_REMOVE, w, w + 1, 0, 0, 0, 0));
    pend_q.push_back(mk(MODE_REMOVE, w + 6, w + 8, 0, 0, 0, 0));
    pend_q.push_back(mk(MODE_REMOVE, w + 8, w + 12, 0, 0, 0, 0));
    pend_q.push_back(mk(MODE_REMOVE, w + 30, w + 30, 0, 0, 0, 0));
    pend_q.push_back(mk(MODE_ALLOC, 0, 0, 0, 1, 5, 0));
    pend_q.push_back(mk(MODE_ALLOC, 0, 0, 1, 1, 5, 0));
    pend_q.push_back(mk(MODE_ALLOC, 0, 0, 48'hFFFF_FFFF_FFFF, 1, 5, 0));
    pend_q.push_back(mk(MODE_ALLOC, 0, 0, 4096, 1, 5, 0));
    pend_q.push_back(mk(MODE_INSERT, w + 40, w + 44, 0, 1, 1, 0));
    pend_q.push_back(mk(MODE_REMOVE, w + 40, w + 44, 0, 0, 0, 0));
    pend_q.push_back(mk(MODE_INSERT, PG_TOP - 2, 0, 0, 8'hFF, 8'hFF, 8'hFF));
    pend_q[$].a_end = 48'hFFFF_FFFF_FFFF;
    pend_q.push_back(mk(MODE_LOOKUP, PG_TOP, 0, 0, 0, 0, 0));
    pend_q[$].a_start = 48'hFFFF_FFFF_FFFF;
    pend_q.push_back(mk(MODE_REMOVE, PG_TOP - 1, PG_TOP, 0, 0, 0, 0));
    drain();
    run_phase(w, 220, 0);

    w = PG_TOP - 400;
    cfg_write(CFG_HEAP_BREAK, 48'(w << PAGE_BITS));
    cfg_write(CFG_MMAP_TOP, 48'hFFFF_FFFF_FFFF);
    cfg_write(CFG_GUARD, 0);
    cfg_write(CFG_HEAP_KIND, 8'hFF);
    cfg_write(CFG_STACK_KIND, 8'h00);
    cfg_write(CFG_NO_MERGE, 8'hFF);
    no_gaps = 1;
    run_phase(w, 200, 1);
    no_gaps = 0;

    w = 0;
    cfg_write(CFG_HEAP_BREAK, 0);
    cfg_write(CFG_MMAP_TOP, 48'(320 << PAGE_BITS));
    cfg_write(CFG_GUARD, 16'hFFFF);
    cfg_write(CFG_NO_MERGE, 8'h00);
    run_phase(w, 200, 1);

    w = 64'h2345;
    cfg_write(CFG_HEAP_BREAK, 48'hFFFF_FFFF_FFFF);
    cfg_write(CFG_GUARD, 0);
    cfg_write(CFG_MMAP_TOP, 48'((w + 320) << PAGE_BITS));
    run_phase(w, 180, 1);

    // fill the region table, then cut holes, which are refused as splits while it stays full
    w = 64'h50000;
    cfg_write(CFG_HEAP_BREAK, 48'(w << PAGE_BITS));
    cfg_write(CFG_MMAP_TOP, 48'((w + 600) << PAGE_BITS));
    cfg_write(CFG_NO_MERGE, 8'h01);
    repeat (70) pend_q.push_back(mk(MODE_REMOVE, 0, PG_TOP, 0, 0, 5, 0));
    for (int k = 0; k < 70; k++)
      pend_q.push_back(mk(MODE_INSERT, w + 8 * k, w + 8 * k + 4, 0, 0, 5, 0));
    pend_q.push_back(mk(MODE_REMOVE, w + 1, w + 2, 0, 0, 0, 0));
    for (int k = 0; k < 70; k++)
      pend_q.push_back(mk(MODE_REMOVE, w + 8 * k + 1, w + 8 * k + 2, 0, 0, 0, 0));
    drain();
    run_phase(w, 100, 0);

    w = 64'h9000;
    cfg_write(CFG_HEAP_BREAK, 48'(w << PAGE_BITS) + 48'h123);
    cfg_write(CFG_MMAP_TOP, 48'(((w + 320) << PAGE_BITS) + 64'hABC));
    cfg_write(CFG_GUARD, 8);
    cfg_write(CFG_HEAP_KIND, 8'd3);
    cfg_write(CFG_STACK_KIND, 8'd4);
    cfg_write(CFG_NO_MERGE, 8'h02);
    run_phase(w, 240, 1);

    repeat (500) @(posedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("timeout");
    $display("== FAIL ==");
    $finish;
  end

endmodule

// File: region_table_allocator.f
sv/rta_pkg.sv
sv/rta_ctrl.sv
sv/rta_dp.sv
sv/region_table_allocator.sv
verif/tb_top.sv
